>>> rtl/bpsd_pkg.sv
// Shared types and constants of the BMP pixel stream decoder.
// Used by the control, output register and top-level modules; depends on nothing.
package bpsd_pkg;

  // Largest image dimension that the format check accepts.
  localparam int unsigned MaxDim = 1024;

  localparam int unsigned BppW     = 6;
  localparam int unsigned DimW     = 11;
  localparam int unsigned CompW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned IndexW   = 20;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned ArgbW    = 32;
  localparam int unsigned SlotW    = 8;
  // Row byte counter: up to 2047 pixels of four bytes, rounded up to four.
  localparam int unsigned RowByteW = 13;

  localparam logic [CfgIdxW-1:0] RegBitsPerPixel   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageWidth     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegImageHeight    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCompressionMode = 3'd3;

  localparam logic [BppW-1:0]  ResetBpp    = 6'd32;
  localparam logic [DimW-1:0]  ResetWidth  = 11'd1024;
  localparam logic [DimW-1:0]  ResetHeight = 11'd1024;
  localparam logic [CompW-1:0] ResetComp   = 4'd0;
  localparam logic [IndexW-1:0] ResetRowBase = IndexW'((1024 - 1) * 1024);

  typedef enum logic [1:0] {
    StPixel     = 2'd0,
    StBadFormat = 2'd1,
    StBeyondEnd = 2'd2
  } status_e;

  // One result on its way to the output register.
  typedef struct packed {
    status_e             status;
    logic [IndexW-1:0]   dest_idx;
    logic [ArgbW-1:0]    argb;
    logic                last_pixel;
    logic                use_palette;
    logic                index_zero;
  } result_t;

endpackage

>>> rtl/bmp_pixel_stream_decoder.sv
// BMP pixel stream decoder: converts BMP pixel-data bytes into ARGB8888 pixels.
// Instantiates bpsd_ctrl, bpsd_ram and bpsd_out; depends on bpsd_pkg.
//
// Input channel (in_valid_i/in_ready_o): one transfer per byte of the pixel
// data area in file order (func_i = 0), or one palette entry write (func_i = 1).
// Output channel (out_valid_o/out_ready_i): at most one result per input
// transfer: a pixel with its top-down index, a bad-format status or a
// beyond-image-end status. Padding bytes and partial pixels give nothing.
// Configuration channel (cfg_valid_i/cfg_ready_o): writes the pixel depth,
// image width, image height or compression mode; any write restarts the image.
// Always ready; the user must use it only while the block is idle (unchecked).
//
// Throughput is one byte per cycle while the receiver does not stall. A
// result appears in the cycle after its input transfer, held in the output
// register together with the palette RAM read data, which is read in the
// same cycle as the byte is taken. When the receiver stalls, the output
// register holds its result and the input is held off until that result is
// taken; a new byte is accepted in the very cycle the held result leaves.
// Reset restores the default configuration (32 bits, 1024 by 1024) and clears
// the counters; the palette is undefined until loaded.
module bmp_pixel_stream_decoder import bpsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [7:0]          data_byte_i,
  input  logic [SlotW-1:0]    palette_slot_i,
  input  logic [RgbW-1:0]     palette_rgb_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [IndexW-1:0]   pixel_index_o,
  output logic [ArgbW-1:0]    argb_o,
  output logic                last_pixel_o
);

  logic            accept;
  logic            load;
  logic            res_valid;
  result_t         res;
  logic [RgbW-1:0] pal_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = load;
  assign accept      = in_valid_i && load;

  bpsd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (accept && !func_i),
    .data_byte_i  (data_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  bpsd_ram #(
    .Width (RgbW),
    .Depth (256)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (accept && func_i),
    .re_i    (accept && !func_i),
    .addr_i  (func_i ? palette_slot_i : data_byte_i),
    .wdata_i (palette_rgb_i),
    .rdata_o (pal_rdata)
  );

  bpsd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .pal_rdata_i   (pal_rdata),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .pixel_index_o (pixel_index_o),
    .argb_o        (argb_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

>>> rtl/bpsd_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; holds the palette of the BMP pixel stream decoder.
module bpsd_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bpsd_ctrl.sv
// Configuration registers, row and pixel counters and byte gathering.
// Depends on bpsd_pkg; produces one result per transfer that causes one.
module bpsd_ctrl import bpsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                byte_valid_i,
  input  logic [7:0]          data_byte_i,
  output logic                res_valid_o,
  output result_t             res_o
);

  logic [BppW-1:0]     bpp_q, bpp_d;
  logic [DimW-1:0]     width_q, width_d;
  logic [DimW-1:0]     height_q, height_d;
  logic [CompW-1:0]    comp_q, comp_d;
  logic [RgbW-1:0]     gather_q, gather_d;
  logic [1:0]          bip_q, bip_d;
  logic [DimW-1:0]     col_q, col_d;
  logic [RowByteW-1:0] rbc_q, rbc_d;
  logic [DimW-1:0]     row_q, row_d;
  logic [IndexW-1:0]   base_q, base_d;

  logic                cfg_hit;
  logic [2*DimW-1:0]   base_prod;
  logic                fmt_ok;
  logic [2:0]          bytes_px;
  logic [RowByteW-1:0] pixel_bytes;
  logic [RowByteW-1:0] row_span;
  logic [RowByteW-1:0] rbc_inc;
  logic [ArgbW-1:0]    argb_direct;

  // Register writes and the new row base that follows from them.
  always_comb begin
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    comp_d   = comp_q;
    cfg_hit  = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBitsPerPixel: begin
          bpp_d   = cfg_data_i[BppW-1:0];
          cfg_hit = 1'b1;
        end
        RegImageWidth: begin
          width_d = cfg_data_i[DimW-1:0];
          cfg_hit = 1'b1;
        end
        RegImageHeight: begin
          height_d = cfg_data_i[DimW-1:0];
          cfg_hit  = 1'b1;
        end
        RegCompressionMode: begin
          comp_d  = cfg_data_i[CompW-1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    base_prod = (2*DimW)'(height_d - 11'd1) * (2*DimW)'(width_d);
  end

  assign fmt_ok = (bpp_q == 6'd8 || bpp_q == 6'd24 || bpp_q == 6'd32) && (comp_q == '0) &&
                  (32'(width_q) <= MaxDim) && (32'(height_q) <= MaxDim);

  always_comb begin
    unique case (bpp_q)
      6'd8: begin
        bytes_px    = 3'd1;
        pixel_bytes = RowByteW'(width_q);
      end
      6'd24: begin
        bytes_px    = 3'd3;
        pixel_bytes = RowByteW'(width_q) + (RowByteW'(width_q) << 1);
      end
      default: begin
        bytes_px    = 3'd4;
        pixel_bytes = RowByteW'(width_q) << 2;
      end
    endcase
    // Rows are padded up to a multiple of four bytes.
    row_span = (pixel_bytes + RowByteW'(3)) & ~RowByteW'(3);
  end

  assign rbc_inc     = rbc_q + RowByteW'(1);
  assign argb_direct = {8'h00, gather_q} | (ArgbW'(data_byte_i) << {bip_q, 3'b000});

  always_comb begin
    gather_d = gather_q;
    bip_d    = bip_q;
    col_d    = col_q;
    rbc_d    = rbc_q;
    row_d    = row_q;
    base_d   = base_q;

    res_valid_o       = 1'b0;
    res_o.status      = StPixel;
    res_o.dest_idx    = '0;
    res_o.argb        = '0;
    res_o.last_pixel  = 1'b0;
    res_o.use_palette = 1'b0;
    res_o.index_zero  = 1'b0;

    if (cfg_hit) begin
      // Any register write restarts the image; the palette is kept.
      gather_d = '0;
      bip_d    = '0;
      col_d    = '0;
      rbc_d    = '0;
      row_d    = '0;
      base_d   = (height_d == '0) ? '0 : base_prod[IndexW-1:0];
    end else if (byte_valid_i) begin
      priority if (!fmt_ok) begin
        res_valid_o  = 1'b1;
        res_o.status = StBadFormat;
      end else if (width_q == '0 || height_q == '0 || row_q >= height_q) begin
        res_valid_o  = 1'b1;
        res_o.status = StBeyondEnd;
      end else begin
        if (rbc_q < pixel_bytes) begin
          if ({1'b0, bip_q} + 3'd1 >= bytes_px) begin
            res_valid_o       = 1'b1;
            res_o.dest_idx    = base_q + IndexW'(col_q);
            res_o.argb        = argb_direct;
            res_o.use_palette = (bytes_px == 3'd1);
            res_o.index_zero  = (data_byte_i == 8'h00);
            res_o.last_pixel  = ({1'b0, row_q} + 12'd1 == {1'b0, height_q}) &&
                                ({1'b0, col_q} + 12'd1 == {1'b0, width_q});
            col_d    = col_q + DimW'(1);
            bip_d    = '0;
            gather_d = '0;
          end else begin
            gather_d = argb_direct[RgbW-1:0];
            bip_d    = bip_q + 2'd1;
          end
        end
        rbc_d = rbc_inc;
        if (rbc_inc >= row_span) begin
          rbc_d    = '0;
          col_d    = '0;
          bip_d    = '0;
          gather_d = '0;
          row_d    = row_q + DimW'(1);
          base_d   = base_q - IndexW'(width_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= ResetBpp;
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      comp_q   <= ResetComp;
      gather_q <= '0;
      bip_q    <= '0;
      col_q    <= '0;
      rbc_q    <= '0;
      row_q    <= '0;
      base_q   <= ResetRowBase;
    end else begin
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      comp_q   <= comp_d;
      gather_q <= gather_d;
      bip_q    <= bip_d;
      col_q    <= col_d;
      rbc_q    <= rbc_d;
      row_q    <= row_d;
      base_q   <= base_d;
    end
  end

endmodule

>>> rtl/bpsd_out.sv
// Output register of the BMP pixel stream decoder; merges in the palette read data.
// Depends on bpsd_pkg; the palette RAM read is issued in the cycle the result is loaded.
module bpsd_out import bpsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  result_t           res_i,
  input  logic [RgbW-1:0]   pal_rdata_i,
  output logic              load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [IndexW-1:0] pixel_index_o,
  output logic [ArgbW-1:0]  argb_o,
  output logic              last_pixel_o
);

  logic    valid_q;
  result_t res_q;

  // The register may take a new result whenever it is empty or the held one leaves this cycle.
  assign load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = res_q.status;
  assign pixel_index_o = res_q.dest_idx;
  assign last_pixel_o  = res_q.last_pixel;
  assign argb_o        = !res_q.use_palette ? res_q.argb :
                         (res_q.index_zero ? '0 : {8'h00, pal_rdata_i});

endmodule
